### sv/netab_pkg.sv
// Shared types and constants for the neighbour expiry table.
// Used by netab_ctrl, netab_dp and neighbor_expiry_table; depends on nothing.
package netab_pkg;

    localparam int KIND_W     = 3;
    localparam int NET_ADDR_W = 32;
    localparam int TIME_W     = 40;
    localparam int MAC_W      = 48;

    // Slave-side tdata: net_addr, now_time, expire_delta, resolved_mac, tx_fail_mac.
    localparam int IN_DATA_W  = NET_ADDR_W + 2 * TIME_W + 2 * MAC_W;
    // Master-side tdata: failed_addr, found, remaining_time, table_full.
    localparam int OUT_USED_W = NET_ADDR_W + 1 + TIME_W + 1;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_ADDR_BITS   = 32;

    localparam logic [KIND_W-1:0] KIND_IS_NEIGHBOR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRE_QUERY = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATE       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TX_ERROR     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PURGE_TICK   = 3'd4;

    localparam logic RES_DONE      = 1'b0;
    localparam logic RES_LINK_FAIL = 1'b1;

    typedef struct packed {
        logic capture;
        logic pass_init;
        logic run_search;
        logic run_purge;
        logic do_update;
        logic do_insert;
        logic emit_done;
    } cmd_t;

    typedef struct packed {
        logic pass_done;
        logic hit;
        logic out_free;
    } status_t;

endpackage

### sv/netab_ctrl.sv
// Controller state machine for the neighbour expiry table.
// Sequences search, purge, update and insert passes; depends on netab_pkg.
module netab_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [netab_pkg::KIND_W-1:0] in_kind,
    output logic                        in_ready,
    output netab_pkg::cmd_t             cmd,
    input  netab_pkg::status_t          status
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_PURGE  = 6'b000100,
        S_UPDATE = 6'b001000,
        S_INSERT = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [netab_pkg::KIND_W-1:0] kind_reg;
    logic [netab_pkg::KIND_W-1:0] kind_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture   = 1'b1;
                    cmd.pass_init = 1'b1;
                    kind_next     = in_kind;
                    priority if (in_kind == netab_pkg::KIND_UPDATE)
                        state_next = S_SEARCH;
                    else if (in_kind == netab_pkg::KIND_IS_NEIGHBOR ||
                             in_kind == netab_pkg::KIND_EXPIRE_QUERY ||
                             in_kind == netab_pkg::KIND_TX_ERROR ||
                             in_kind == netab_pkg::KIND_PURGE_TICK)
                        state_next = S_PURGE;
                    else
                        state_next = S_DONE;
                end
            end
            S_SEARCH:
            begin
                cmd.run_search = 1'b1;
                if (status.pass_done)
                begin
                    if (status.hit)
                    begin
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        cmd.pass_init = 1'b1;
                        state_next    = S_PURGE;
                    end
                end
            end
            S_PURGE:
            begin
                cmd.run_purge = 1'b1;
                if (status.pass_done)
                    state_next = (kind_reg == netab_pkg::KIND_UPDATE) ? S_INSERT : S_DONE;
            end
            S_UPDATE:
            begin
                cmd.do_update = 1'b1;
                state_next    = S_DONE;
            end
            S_INSERT:
            begin
                cmd.do_insert = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                cmd.emit_done = 1'b1;
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= netab_pkg::KIND_IS_NEIGHBOR;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

### sv/netab_dp.sv
// Datapath of the neighbour expiry table: entry memory, valid bits, slot scan
// pipeline, result register and the report enable. Depends on netab_pkg.
module netab_dp
#(
    parameter int TABLE_DEPTH = netab_pkg::DEF_TABLE_DEPTH,
    parameter int ADDR_BITS   = netab_pkg::DEF_ADDR_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    input  logic [netab_pkg::KIND_W-1:0]    in_kind,
    input  logic [netab_pkg::IN_DATA_W-1:0] in_data,
    input  netab_pkg::cmd_t                 cmd,
    output netab_pkg::status_t              status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [netab_pkg::OUT_DATA_W-1:0] out_data,
    output logic                            out_user,
    output logic                            out_last
);

    localparam int KEY_W = (ADDR_BITS < netab_pkg::NET_ADDR_W) ? ADDR_BITS
                                                                : netab_pkg::NET_ADDR_W;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] END_CNT = CNT_W'(TABLE_DEPTH);

    localparam int TW   = netab_pkg::TIME_W;
    localparam int MW   = netab_pkg::MAC_W;
    localparam int AW   = netab_pkg::NET_ADDR_W;
    localparam int NOW_LO   = AW;
    localparam int DELTA_LO = NOW_LO + TW;
    localparam int RMAC_LO  = DELTA_LO + TW;
    localparam int FMAC_LO  = RMAC_LO + MW;
    localparam int PAD_W    = netab_pkg::OUT_DATA_W - netab_pkg::OUT_USED_W;

    typedef struct packed {
        logic [TW-1:0]    expiry;
        logic [MW-1:0]    mac;
        logic [KEY_W-1:0] key;
    } entry_t;

    entry_t mem [0:TABLE_DEPTH-1];

    // Captured item.
    logic [netab_pkg::KIND_W-1:0] kind_reg;
    logic [KEY_W-1:0]             key_reg;
    logic [TW-1:0]                now_reg;
    logic [TW-1:0]                newexp_reg;
    logic [MW-1:0]                rmac_reg;
    logic [MW-1:0]                fmac_reg;
    logic [TW:0]                  exp_sum;

    // Scan pipeline: read issued at cnt_reg into rd_q_reg, evaluated from that register.
    logic [CNT_W-1:0]       cnt_reg;
    logic                   ev_valid_reg;
    logic [IDX_W-1:0]       ev_idx_reg;
    entry_t                 rd_q_reg;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   report_en_reg;
    logic                   found_reg;
    logic                   free_found_reg;
    logic                   full_reg;
    logic [IDX_W-1:0]       hit_idx_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    entry_t                 hit_entry_reg;
    logic [TW-1:0]          rem_reg;

    logic                   out_valid_reg;
    logic                   out_user_reg;
    logic                   out_last_reg;
    logic [AW-1:0]          out_addr_reg;
    logic                   out_found_reg;
    logic [TW-1:0]          out_rem_reg;
    logic                   out_full_reg;

    logic       slot_valid;
    logic       key_match;
    logic       expired;
    logic       mac_fail;
    logic       purge_now;
    logic       need_report;
    logic       out_free;
    logic       stall;
    logic       run;
    logic       advance;
    logic       issue;
    logic       eval_go;
    logic       take_match;
    logic       take_free;
    logic       load_rep;
    logic       load_done;
    logic       mem_we;
    logic [IDX_W-1:0] mem_widx;
    entry_t     mem_wdata;
    entry_t     upd_entry;
    entry_t     ins_entry;
    logic       done_found;
    logic [TW-1:0] done_rem;
    logic       done_full;

    assign exp_sum = {1'b0, in_data[DELTA_LO-1:NOW_LO]} + {1'b0, in_data[RMAC_LO-1:DELTA_LO]};

    // A transmit error marks an entry closed and the same pass removes it, so
    // a closed mark never outlives the item that sets it and needs no storage.
    assign slot_valid  = valid_reg[ev_idx_reg];
    assign key_match   = slot_valid && (rd_q_reg.key == key_reg);
    assign expired     = rd_q_reg.expiry < now_reg;
    assign mac_fail    = (kind_reg == netab_pkg::KIND_TX_ERROR) && (rd_q_reg.mac == fmac_reg);
    assign purge_now   = cmd.run_purge && ev_valid_reg && slot_valid && (expired || mac_fail);
    assign need_report = purge_now && report_en_reg;
    assign out_free    = !out_valid_reg || out_ready;
    assign stall       = need_report && !out_free;
    assign run         = cmd.run_search || cmd.run_purge;
    assign advance     = run && !stall;
    assign issue       = advance && (cnt_reg != END_CNT);
    assign eval_go     = advance && ev_valid_reg;
    assign take_match  = eval_go && key_match && !found_reg && !purge_now;
    assign take_free   = eval_go && cmd.run_purge && !free_found_reg && (!slot_valid || purge_now);
    assign load_rep    = eval_go && need_report;
    assign load_done   = cmd.emit_done && out_free;

    assign status.pass_done = advance && (cnt_reg == END_CNT);
    assign status.hit       = found_reg || take_match;
    assign status.out_free  = out_free;

    always_comb
    begin
        upd_entry.key    = hit_entry_reg.key;
        upd_entry.expiry = (newexp_reg > hit_entry_reg.expiry) ? newexp_reg
                                                               : hit_entry_reg.expiry;
        upd_entry.mac    = (hit_entry_reg.mac == '0) ? rmac_reg : hit_entry_reg.mac;
        ins_entry.key    = key_reg;
        ins_entry.expiry = newexp_reg;
        ins_entry.mac    = rmac_reg;
        mem_we    = cmd.do_update || (cmd.do_insert && free_found_reg);
        mem_widx  = cmd.do_update ? hit_idx_reg : free_idx_reg;
        mem_wdata = cmd.do_update ? upd_entry : ins_entry;
    end

    always_comb
    begin
        done_found = found_reg && (kind_reg == netab_pkg::KIND_IS_NEIGHBOR ||
                                   kind_reg == netab_pkg::KIND_EXPIRE_QUERY ||
                                   kind_reg == netab_pkg::KIND_UPDATE);
        done_rem   = (found_reg && kind_reg == netab_pkg::KIND_EXPIRE_QUERY) ? rem_reg : '0;
        done_full  = full_reg && (kind_reg == netab_pkg::KIND_UPDATE);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_widx] <= mem_wdata;
        if (issue)
            rd_q_reg <= mem[cnt_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= in_kind;
            key_reg    <= in_data[KEY_W-1:0];
            now_reg    <= in_data[DELTA_LO-1:NOW_LO];
            newexp_reg <= exp_sum[TW] ? {TW{1'b1}} : exp_sum[TW-1:0];
            rmac_reg   <= in_data[FMAC_LO-1:RMAC_LO];
            fmac_reg   <= in_data[FMAC_LO+MW-1:FMAC_LO];
        end
        if (advance)
            ev_idx_reg <= cnt_reg[IDX_W-1:0];
        if (take_match)
        begin
            hit_idx_reg   <= ev_idx_reg;
            hit_entry_reg <= rd_q_reg;
            rem_reg       <= rd_q_reg.expiry - now_reg;
        end
        if (take_free)
            free_idx_reg <= ev_idx_reg;
        if (load_rep)
        begin
            out_user_reg  <= netab_pkg::RES_LINK_FAIL;
            out_last_reg  <= 1'b0;
            out_addr_reg  <= AW'(rd_q_reg.key);
            out_found_reg <= 1'b0;
            out_rem_reg   <= '0;
            out_full_reg  <= 1'b0;
        end
        else if (load_done)
        begin
            out_user_reg  <= netab_pkg::RES_DONE;
            out_last_reg  <= 1'b1;
            out_addr_reg  <= '0;
            out_found_reg <= done_found;
            out_rem_reg   <= done_rem;
            out_full_reg  <= done_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            ev_valid_reg   <= 1'b0;
            valid_reg      <= '0;
            report_en_reg  <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            full_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                report_en_reg <= cfg_wdata;

            if (cmd.pass_init)
            begin
                cnt_reg      <= '0;
                ev_valid_reg <= 1'b0;
            end
            else if (advance)
            begin
                cnt_reg      <= cnt_reg + CNT_W'(issue);
                ev_valid_reg <= issue;
            end

            if (cmd.capture)
            begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                full_reg       <= 1'b0;
            end
            else
            begin
                if (take_match)
                    found_reg <= 1'b1;
                if (take_free)
                    free_found_reg <= 1'b1;
                if (cmd.do_insert && !free_found_reg)
                    full_reg <= 1'b1;
            end

            if (eval_go && purge_now)
                valid_reg[ev_idx_reg] <= 1'b0;
            if (cmd.do_insert && free_found_reg)
                valid_reg[free_idx_reg] <= 1'b1;

            if (load_rep || load_done)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {{PAD_W{1'b0}}, out_full_reg, out_rem_reg, out_found_reg, out_addr_reg};

endmodule

### sv/neighbor_expiry_table.sv
// Neighbour expiry table, top level: joins the controller and the datapath.
// Depends on netab_pkg, netab_ctrl and netab_dp.
//
// Each input beat is handled alone, one item at a time. A query, transmit error or
// purge tick takes one pass over the table at one slot a cycle through the entry
// memory's read port while the scan is not waiting; an update that hits takes a
// search pass and then rewrites the entry, and one that misses takes a search and
// a purge pass before the insert. While reporting is enabled, every purged entry
// adds a link failure beat in slot order, and the scan waits while such a beat is
// due and the result register is still held by the sink. The last beat of an item
// always carries tlast, and the next item is taken while that beat still waits.
// Entry contents need no clearing after reset; the valid bits are cleared at once.
module neighbor_expiry_table
#(
    parameter int TABLE_DEPTH = netab_pkg::DEF_TABLE_DEPTH,
    parameter int ADDR_BITS   = netab_pkg::DEF_ADDR_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,      // link_fail_report_enable
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // net_addr, now_time, expire_delta, resolved_mac, tx_fail_mac
    input  logic [netab_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [netab_pkg::KIND_W-1:0]     s_axis_tuser,   // kind
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // failed_addr, found, remaining_time, table_full, zero padding
    output logic [netab_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [0:0]                       m_axis_tuser,   // result_kind
    output logic                             m_axis_tlast
);

    netab_pkg::cmd_t    cmd;
    netab_pkg::status_t status;
    logic               res_kind;

    netab_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    netab_dp
    #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_BITS   (ADDR_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_kind   (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (res_kind),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tuser = res_kind;

`ifndef ASSERT_OFF
    a_accept_captures: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> (cmd.capture && cmd.pass_init))
        else $error("accepted beat was not captured");

    a_done_not_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_done |-> !(cmd.run_search || cmd.run_purge))
        else $error("done result issued during a scan pass");

    a_insert_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert |=> cmd.emit_done)
        else $error("insert not followed by the done result");

    a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == netab_pkg::RES_DONE)))
        else $error("tlast does not match the result kind");

    a_full_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[netab_pkg::OUT_USED_W-1]) |-> m_axis_tlast)
        else $error("table_full set on a link failure beat");
`endif

endmodule

### verif/neighbor_expiry_table_tb.sv
// Self-checking testbench for neighbor_expiry_table: directed corner items, a table
// fill with overflow, then random neighbour traffic under three idling patterns.
// Depends on netab_pkg and the neighbor_expiry_table RTL only.
`timescale 1ns / 1ps

module neighbor_expiry_table_tb;

    localparam int SLOTS      = netab_pkg::DEF_TABLE_DEPTH;
    localparam int KIND_W     = netab_pkg::KIND_W;
    localparam int NET_ADDR_W = netab_pkg::NET_ADDR_W;
    localparam int TIME_W     = netab_pkg::TIME_W;
    localparam int MAC_W      = netab_pkg::MAC_W;
    localparam int IN_DATA_W  = netab_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = netab_pkg::OUT_DATA_W;
    localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [MAC_W-1:0]  MAC_NONE = '0;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [NET_ADDR_W-1:0] net_addr;
        logic [TIME_W-1:0]     now_time;
        logic [TIME_W-1:0]     expire_delta;
        logic [MAC_W-1:0]      resolved_mac;
        logic [MAC_W-1:0]      tx_fail_mac;
    } table_item_t;

    typedef struct packed {
        logic                  result_kind;
        logic [NET_ADDR_W-1:0] failed_addr;
        logic                  found;
        logic [TIME_W-1:0]     remaining_time;
        logic                  table_full;
        logic                  last;
    } table_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [KIND_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    // Shadow copy of the neighbour table and its report switch.
    logic                  shadow_valid  [SLOTS];
    logic                  shadow_closed [SLOTS];
    logic [NET_ADDR_W-1:0] shadow_addr   [SLOTS];
    logic [MAC_W-1:0]      shadow_mac    [SLOTS];
    logic [TIME_W-1:0]     shadow_expiry [SLOTS];
    logic                  shadow_report_en;

    table_result_t         due_results[$];
    int                    mismatch_count;
    int                    send_idle_pct;
    int                    recv_stall_pct;
    logic [TIME_W-1:0]     clock_now;
    logic [NET_ADDR_W-1:0] addr_pool [24];
    logic [MAC_W-1:0]      mac_pool  [6];

    neighbor_expiry_table dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[TIME_W-1:0];
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[MAC_W-1:0];
    endfunction

    function automatic table_item_t make_item(logic [KIND_W-1:0] kind,
                                              logic [NET_ADDR_W-1:0] addr,
                                              logic [TIME_W-1:0] now,
                                              logic [TIME_W-1:0] delta,
                                              logic [MAC_W-1:0] rmac,
                                              logic [MAC_W-1:0] fmac);
        table_item_t it;
        it.kind         = kind;
        it.net_addr     = addr;
        it.now_time     = now;
        it.expire_delta = delta;
        it.resolved_mac = rmac;
        it.tx_fail_mac  = fmac;
        return it;
    endfunction

    function automatic void push_result(logic rk, logic [NET_ADDR_W-1:0] addr, logic fnd,
                                        logic [TIME_W-1:0] rem, logic full, logic lst);
        table_result_t r;
        r.result_kind    = rk;
        r.failed_addr    = addr;
        r.found          = fnd;
        r.remaining_time = rem;
        r.table_full     = full;
        r.last           = lst;
        due_results.insert(due_results.size(), r);
    endfunction

    // Drops entries that are stale (expiry strictly before now) or closed, reporting
    // each one in slot order while reporting is on.
    function automatic void purge_stale(logic [TIME_W-1:0] now);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (shadow_valid[i] && (shadow_expiry[i] < now || shadow_closed[i]))
            begin
                if (shadow_report_en)
                    push_result(netab_pkg::RES_LINK_FAIL, shadow_addr[i], 1'b0, '0,
                                1'b0, 1'b0);
                shadow_valid[i]  = 1'b0;
                shadow_closed[i] = 1'b0;
            end
        end
    endfunction

    function automatic int find_neighbour(logic [NET_ADDR_W-1:0] addr);
        for (int i = 0; i < SLOTS; i++)
            if (shadow_valid[i] && shadow_addr[i] == addr)
                return i;
        return -1;
    endfunction

    function automatic void predict_table_item(table_item_t it);
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] new_expiry;
        logic [TIME_W-1:0] rem;
        int                slot;
        sum        = {1'b0, it.now_time} + {1'b0, it.expire_delta};
        new_expiry = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        case (it.kind)
            netab_pkg::KIND_IS_NEIGHBOR, netab_pkg::KIND_EXPIRE_QUERY:
            begin
                purge_stale(it.now_time);
                slot = find_neighbour(it.net_addr);
                if (slot < 0)
                    push_result(netab_pkg::RES_DONE, '0, 1'b0, '0, 1'b0, 1'b1);
                else
                begin
                    rem = '0;
                    if (it.kind == netab_pkg::KIND_EXPIRE_QUERY &&
                        shadow_expiry[slot] >= it.now_time)
                        rem = shadow_expiry[slot] - it.now_time;
                    push_result(netab_pkg::RES_DONE, '0, 1'b1, rem, 1'b0, 1'b1);
                end
            end
            netab_pkg::KIND_UPDATE:
            begin
                slot = find_neighbour(it.net_addr);
                if (slot >= 0)
                begin
                    if (new_expiry > shadow_expiry[slot])
                        shadow_expiry[slot] = new_expiry;
                    if (shadow_mac[slot] == MAC_NONE)
                        shadow_mac[slot] = it.resolved_mac;
                    push_result(netab_pkg::RES_DONE, '0, 1'b1, '0, 1'b0, 1'b1);
                end
                else
                begin
                    purge_stale(it.now_time);
                    slot = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!shadow_valid[i])
                            slot = i;
                    if (slot >= 0)
                    begin
                        shadow_valid[slot]  = 1'b1;
                        shadow_closed[slot] = 1'b0;
                        shadow_addr[slot]   = it.net_addr;
                        shadow_mac[slot]    = it.resolved_mac;
                        shadow_expiry[slot] = new_expiry;
                    end
                    push_result(netab_pkg::RES_DONE, '0, 1'b0, '0, slot < 0, 1'b1);
                end
            end
            netab_pkg::KIND_TX_ERROR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (shadow_valid[i] && shadow_mac[i] == it.tx_fail_mac)
                        shadow_closed[i] = 1'b1;
                purge_stale(it.now_time);
                push_result(netab_pkg::RES_DONE, '0, 1'b0, '0, 1'b0, 1'b1);
            end
            netab_pkg::KIND_PURGE_TICK:
            begin
                purge_stale(it.now_time);
                push_result(netab_pkg::RES_DONE, '0, 1'b0, '0, 1'b0, 1'b1);
            end
            default:
                push_result(netab_pkg::RES_DONE, '0, 1'b0, '0, 1'b0, 1'b1);
        endcase
    endfunction

    // Called just after a rising edge; returns at the edge that accepts the beat, with
    // tvalid still high so that a following item needs no second assignment.
    task automatic send_item(input table_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {it.tx_fail_mac, it.resolved_mac, it.expire_delta,
                          it.now_time, it.net_addr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_table_item(it);
    endtask

    task automatic wait_table_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_report_enable(input logic enable);
        wait_table_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= enable;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_report_en = enable;
    endtask

    function automatic void compare_field(string field_name, logic [63:0] want,
                                          logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field_name, want, got);
        end
    endfunction

    // Result checker and sink-side stall generator.
    always @(posedge clk)
    begin
        table_result_t got;
        table_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.result_kind    = m_axis_tuser[0];
            got.failed_addr    = m_axis_tdata[NET_ADDR_W-1:0];
            got.found          = m_axis_tdata[NET_ADDR_W];
            got.remaining_time = m_axis_tdata[NET_ADDR_W+1 +: TIME_W];
            got.table_full     = m_axis_tdata[NET_ADDR_W+1+TIME_W];
            got.last           = m_axis_tlast;
            if (due_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result beat, expected none, actual 0x%0h",
                         $time, got);
            end
            else
            begin
                want = due_results.pop_front();
                compare_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
                compare_field("failed_addr", 64'(want.failed_addr), 64'(got.failed_addr));
                compare_field("found", 64'(want.found), 64'(got.found));
                compare_field("remaining_time", 64'(want.remaining_time),
                              64'(got.remaining_time));
                compare_field("table_full", 64'(want.table_full), 64'(got.table_full));
                compare_field("last", 64'(want.last), 64'(got.last));
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Field extremes, saturating expiry, hit that fills a missing hardware address,
    // closing by transmit error, and the unused kinds.
    task automatic test_corner_items();
        send_item(make_item(netab_pkg::KIND_IS_NEIGHBOR, '0, '0, '0, '0, '0));
        send_item(make_item(netab_pkg::KIND_UPDATE, '1, TIME_MAX, TIME_MAX, MAC_NONE, '0));
        send_item(make_item(netab_pkg::KIND_UPDATE, '1, 40'd5, 40'd1, '1, '0));
        send_item(make_item(netab_pkg::KIND_EXPIRE_QUERY, '1, '0, '0, '0, '0));
        send_item(make_item(netab_pkg::KIND_TX_ERROR, '0, '0, '0, '0, '1));
        send_item(make_item(netab_pkg::KIND_IS_NEIGHBOR, '1, '0, '0, '0, '0));
        for (int k = 0; k < 3; k++)
            send_item(make_item(KIND_W'(KIND_UNUSED_FIRST + k), $urandom(), rand_time(),
                                rand_time(), rand_mac(), rand_mac()));
    endtask

    // Fills every slot, overflows the table, queries an entry on its expiry instant
    // and then lets one tick purge the whole table.
    task automatic test_fill_and_overflow();
        for (int i = 0; i < SLOTS; i++)
            send_item(make_item(netab_pkg::KIND_UPDATE, 32'h0A00_0000 + NET_ADDR_W'(i),
                                40'd100, 40'd50 + TIME_W'(i),
                                48'h0200_0000_0000 + MAC_W'(i), '0));
        send_item(make_item(netab_pkg::KIND_UPDATE, 32'h0B00_0000, 40'd100, 40'd10,
                            48'h1, '0));
        send_item(make_item(netab_pkg::KIND_EXPIRE_QUERY, 32'h0A00_0000, 40'd150, '0,
                            '0, '0));
        send_item(make_item(netab_pkg::KIND_PURGE_TICK, '0, 40'd1000, '0, '0, '0));
    endtask

    // Mostly plausible neighbour traffic on a moving clock over a small address and
    // hardware address pool, with some unused kinds and fully random beats.
    task automatic test_random_traffic(input int count);
        int                choice;
        logic [MAC_W-1:0]  rmac;
        table_item_t       it;
        for (int n = 0; n < count; n++)
        begin
            clock_now += TIME_W'($urandom_range(0, 12));
            choice = $urandom_range(0, 99);
            rmac   = ($urandom_range(0, 4) == 0) ? MAC_NONE
                                                 : mac_pool[$urandom_range(1, 5)];
            if (choice < 45)
                it = make_item(netab_pkg::KIND_UPDATE, addr_pool[$urandom_range(0, 23)],
                               clock_now, TIME_W'($urandom_range(0, 80)), rmac,
                               rand_mac());
            else if (choice < 65)
                it = make_item($urandom_range(0, 1) ? netab_pkg::KIND_EXPIRE_QUERY
                                                    : netab_pkg::KIND_IS_NEIGHBOR,
                               addr_pool[$urandom_range(0, 23)], clock_now, rand_time(),
                               rand_mac(), rand_mac());
            else if (choice < 75)
                it = make_item(netab_pkg::KIND_TX_ERROR, $urandom(), clock_now,
                               rand_time(), rand_mac(), mac_pool[$urandom_range(0, 5)]);
            else if (choice < 85)
                it = make_item(netab_pkg::KIND_PURGE_TICK, $urandom(), clock_now,
                               rand_time(), rand_mac(), rand_mac());
            else if (choice < 90)
                it = make_item(KIND_W'(KIND_UNUSED_FIRST + $urandom_range(0, 2)),
                               $urandom(), rand_time(), rand_time(), rand_mac(),
                               rand_mac());
            else
                it = make_item(KIND_W'($urandom_range(0, 7)), $urandom(), rand_time(),
                               rand_time(), rand_mac(), rand_mac());
            send_item(it);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = netab_pkg::KIND_IS_NEIGHBOR;
        m_axis_tready  = 1'b0;
        mismatch_count = 0;
        send_idle_pct  = 31;
        recv_stall_pct = 76;
        clock_now      = 40'd2000;
        shadow_report_en = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_valid[i]  = 1'b0;
            shadow_closed[i] = 1'b0;
            shadow_addr[i]   = '0;
            shadow_mac[i]    = '0;
            shadow_expiry[i] = '0;
        end
        foreach (addr_pool[i])
            addr_pool[i] = $urandom();
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        foreach (mac_pool[i])
            mac_pool[i] = rand_mac();
        mac_pool[0] = MAC_NONE;
        mac_pool[1] = '1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        set_report_enable(1'b0);
        test_corner_items();
        set_report_enable(1'b1);
        test_fill_and_overflow();
        test_random_traffic(120);

        send_idle_pct  = 76;
        recv_stall_pct = 31;
        set_report_enable(1'b0);
        test_random_traffic(120);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_report_enable(1'b1);
        test_random_traffic(120);

        wait_table_idle();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
